/* hdl/lfte_pkg.sv */
// Shared constants, datapath command and status types for the line folding block.
package lfte_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_STOP   = 2'd1;

    localparam logic [COL_W-1:0] LINE_WIDTH_RST = 6'd10;
    localparam logic [COL_W-1:0] TAB_STOP_RST   = 6'd5;
    localparam logic [COL_W-1:0] MIN_WIDTH      = 6'd2;
    localparam logic [COL_W-1:0] MAX_WIDTH_C    = COL_W'(MAX_WIDTH);

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_MOD,
        DP_FILL,
        DP_TAB_END,
        DP_SCAN_RD,
        DP_SCAN_DEC,
        DP_SCAN_END,
        DP_EMIT_RD,
        DP_EMIT_PUT,
        DP_EMIT_NL,
        DP_COPY_RD,
        DP_COPY_WR,
        DP_COPY_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tab;
        logic is_nl;
        logic fold_hit;
        logic rem_ge_t;
        logic fill_go;
        logic col_eq_w;
        logic scan_stop;
        logic emit_more;
        logic copy_more;
        logic out_free;
    } dp_sts_t;

endpackage

/* hdl/lfte_dp.sv */
// Datapath: line store, column and index counters, config registers, output register.
module lfte_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lfte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfte_pkg::COL_W-1:0]     cfg_data,
    input  logic [lfte_pkg::CHAR_W-1:0]    in_char,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [lfte_pkg::CHAR_W-1:0]    out_char,
    output logic                           last_of_run,
    input  lfte_pkg::dp_cmd_t              cmd,
    output lfte_pkg::dp_sts_t              sts
);
    import lfte_pkg::*;

    logic [CHAR_W-1:0] mem [MAX_WIDTH];

    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  idx_reg, idx_next;
    logic [COL_W-1:0]  len_reg, len_next;
    logic [COL_W-1:0]  rem_reg, rem_next;
    logic [COL_W-1:0]  line_width_reg, tab_stop_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic [CHAR_W-1:0] rd_data_reg;

    logic [COL_W-1:0]  w_eff, t_eff, i_sat, i_inc, rest, rem_inc, rem_wrap, src_col;
    logic              is_tab, out_free;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CHAR_W-1:0] mem_wdata;

    always_comb
    begin
        if (line_width_reg < MIN_WIDTH)
        begin
            w_eff = MIN_WIDTH;
        end
        else if (line_width_reg > MAX_WIDTH_C)
        begin
            w_eff = MAX_WIDTH_C;
        end
        else
        begin
            w_eff = line_width_reg;
        end
    end

    assign t_eff    = (tab_stop_reg == '0) ? COL_W'(1) : tab_stop_reg;
    assign i_sat    = (col_reg >= w_eff) ? (w_eff - COL_W'(1)) : col_reg;
    assign i_inc    = i_sat + COL_W'(1);
    assign rest     = w_eff - len_reg;
    assign rem_inc  = rem_reg + COL_W'(1);
    assign rem_wrap = (rem_inc == t_eff) ? '0 : rem_inc;
    assign src_col  = len_reg + idx_reg;
    assign is_tab   = (in_char == CH_TAB);
    assign out_free = !out_valid_reg || !out_stall;

    assign sts.is_tab    = is_tab;
    assign sts.is_nl     = (in_char == CH_NL);
    assign sts.fold_hit  = (i_inc == w_eff);
    assign sts.rem_ge_t  = (rem_reg >= t_eff);
    assign sts.fill_go   = (rem_reg != '0) && (col_reg < w_eff);
    assign sts.col_eq_w  = (col_reg == w_eff);
    assign sts.scan_stop = (rd_data_reg != CH_SP) || (idx_reg == '0);
    assign sts.emit_more = (idx_reg < len_reg);
    assign sts.copy_more = (idx_reg < rest);
    assign sts.out_free  = out_free;

    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[ADDR_W-1:0];
        mem_wdata      = rd_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg[ADDR_W-1:0];
        col_next       = col_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (cmd.op)
            DP_ACCEPT:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_sat[ADDR_W-1:0];
                mem_wdata = is_tab ? CH_SP : in_char;
                col_next  = i_inc;
                rem_next  = i_inc;
                idx_next  = sts.is_nl ? '0 : (w_eff - COL_W'(1));
                len_next  = i_sat;
            end
            DP_MOD:
            begin
                rem_next = rem_reg - t_eff;
            end
            DP_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = col_reg[ADDR_W-1:0];
                mem_wdata = CH_SP;
                col_next  = col_reg + COL_W'(1);
                rem_next  = rem_wrap;
            end
            DP_TAB_END:
            begin
                len_next = w_eff;
                idx_next = '0;
            end
            DP_SCAN_RD:
            begin
                mem_re = 1'b1;
            end
            DP_SCAN_DEC:
            begin
                idx_next = idx_reg - COL_W'(1);
            end
            DP_SCAN_END:
            begin
                // keep everything up to the last nonblank; an all-blank line goes out whole
                len_next = (rd_data_reg != CH_SP) ? (idx_reg + COL_W'(1)) : w_eff;
                idx_next = '0;
            end
            DP_EMIT_RD:
            begin
                mem_re = 1'b1;
            end
            DP_EMIT_PUT:
            begin
                idx_next       = idx_reg + COL_W'(1);
                out_valid_next = 1'b1;
                out_char_next  = rd_data_reg;
                out_last_next  = 1'b0;
            end
            DP_EMIT_NL:
            begin
                col_next       = '0;
                idx_next       = '0;
                out_valid_next = 1'b1;
                out_char_next  = CH_NL;
                out_last_next  = 1'b1;
            end
            DP_COPY_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = src_col[ADDR_W-1:0];
            end
            DP_COPY_WR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + COL_W'(1);
            end
            DP_COPY_END:
            begin
                col_next = rest;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            out_valid_reg  <= 1'b0;
            line_width_reg <= LINE_WIDTH_RST;
            tab_stop_reg   <= TAB_STOP_RST;
        end
        else
        begin
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_LINE_WIDTH))
            begin
                line_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_TAB_STOP))
            begin
                tab_stop_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_EMIT_PUT || cmd.op == DP_EMIT_NL) |-> out_free)
        else $error("output register loaded while held");

    a_fill_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_FILL) |-> (col_reg < w_eff))
        else $error("tab fill beyond line width");

    a_copy_src: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_COPY_RD) |-> (({1'b0, len_reg} + {1'b0, idx_reg}) < {1'b0, w_eff}))
        else $error("carry copy reads beyond line width");

endmodule

/* hdl/lfte_ctrl.sv */
// Controller: sequences accept, tab fill, blank scan, line emit and carry copy.
module lfte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lfte_pkg::dp_sts_t sts,
    output lfte_pkg::dp_cmd_t cmd
);
    import lfte_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_MOD      = 10'b0000000010,
        ST_FILL     = 10'b0000000100,
        ST_SCAN_RD  = 10'b0000001000,
        ST_SCAN_CHK = 10'b0000010000,
        ST_EMIT_RD  = 10'b0000100000,
        ST_EMIT_PUT = 10'b0001000000,
        ST_EMIT_NL  = 10'b0010000000,
        ST_COPY_RD  = 10'b0100000000,
        ST_COPY_WR  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   fold_reg, fold_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        fold_next  = fold_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op    = DP_ACCEPT;
                    fold_next = 1'b0;
                    if (sts.is_tab)
                    begin
                        state_next = ST_MOD;
                    end
                    else if (sts.is_nl)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else if (sts.fold_hit)
                    begin
                        state_next = ST_SCAN_RD;
                        fold_next  = 1'b1;
                    end
                end
            end
            ST_MOD:
            begin
                if (sts.rem_ge_t)
                begin
                    cmd.op = DP_MOD;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (sts.fill_go)
                begin
                    cmd.op = DP_FILL;
                end
                else if (sts.col_eq_w)
                begin
                    cmd.op     = DP_TAB_END;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                cmd.op     = DP_SCAN_RD;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (sts.scan_stop)
                begin
                    cmd.op     = DP_SCAN_END;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    cmd.op     = DP_SCAN_DEC;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD:
            begin
                if (sts.emit_more)
                begin
                    cmd.op     = DP_EMIT_RD;
                    state_next = ST_EMIT_PUT;
                end
                else
                begin
                    state_next = ST_EMIT_NL;
                end
            end
            ST_EMIT_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = DP_EMIT_PUT;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = DP_EMIT_NL;
                    state_next = fold_reg ? ST_COPY_RD : ST_IDLE;
                end
            end
            ST_COPY_RD:
            begin
                if (sts.copy_more)
                begin
                    cmd.op     = DP_COPY_RD;
                    state_next = ST_COPY_WR;
                end
                else
                begin
                    cmd.op     = DP_COPY_END;
                    state_next = ST_IDLE;
                end
            end
            ST_COPY_WR:
            begin
                cmd.op     = DP_COPY_WR;
                state_next = ST_COPY_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fold_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fold_reg  <= fold_next;
        end
    end

    a_copy_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_WR) |-> fold_reg)
        else $error("carry copy without a fold");

    a_nl_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sts.is_nl) |=> (state_reg == ST_EMIT_RD))
        else $error("newline did not start a line emit");

    a_nl_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_NL && sts.out_free) |=>
        (state_reg == ST_IDLE || state_reg == ST_COPY_RD))
        else $error("newline transfer did not end the emit");

endmodule

/* hdl/line_fold_tab_expand.sv */
// Top level of the line folding and tab expansion block.
// One character is taken per input transfer and buffered at the current column; the block
// stalls its input until all work for that character is done, but a finished output byte may
// still wait in the output register while the next character is taken. A plain byte that does
// not fill the line needs no further work. A tab subtracts the tab stop from the column just
// past its first blank, one subtraction at a time (column / tab_stop of them), and then fills
// each further blank. A newline, a tab that reaches the width and a byte that fills the line
// each then emit the buffered columns, reading each byte from the line store and then putting
// it out, followed by the closing newline; the output side can stall the emit. A fold first
// scans back over trailing blanks, one column at a time, and after the emit moves the carried
// blanks to the start of the line, one blank at a time, and then closes the copy. The line
// store has registered read data and no reset, and needs no clearing pass; columns are only
// read after they have been written. Config writes are meant to happen while the block is
// idle; index 0 is line_width, index 1 is tab_stop, others drop.
module line_fold_tab_expand (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lfte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfte_pkg::COL_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lfte_pkg::CHAR_W-1:0]    in_char,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lfte_pkg::CHAR_W-1:0]    out_char,
    output logic                           last_of_run
);
    import lfte_pkg::*;

    // command from the controller, status back from the datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    lfte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfte_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_char     (in_char),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

/* bench/line_fold_tab_expand_test.sv */
// Self-checking regression for the line folding and tab expansion block.
module line_fold_tab_expand_test;

    import lfte_pkg::*;

    // Spare register indexes: the block must drop writes to these.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Cycles to let pass once the last expected byte has arrived; covers a tab fill
    // or a carried-blank copy that still runs after the final result.
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LINE_WIDTH;
    logic [COL_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CHAR_W-1:0]    in_char = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CHAR_W-1:0]    out_char;
    logic                 last_of_run;

    // Characters waiting to be sent and bytes the folder should emit.
    logic [CHAR_W-1:0] pending_chars[$];
    out_byte_t         line_expect[$];

    // Mirror of the block: registers, column count and line buffer.
    logic [COL_W-1:0]  width_reg = LINE_WIDTH_RST;
    logic [COL_W-1:0]  tab_reg = TAB_STOP_RST;
    logic [COL_W-1:0]  col_count = '0;
    logic [CHAR_W-1:0] line_buf[MAX_WIDTH];

    bit idle_on = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int mismatches = 0;

    line_fold_tab_expand i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run, even with every fold stalled.
    initial
    begin
        #20_000_000;
        $display("line_fold_tab_expand regression: fail");
        $finish;
    end

    // Queue columns [0, len) of the line buffer and a closing newline.
    function automatic void emit_columns(input int len);
        for (int k = 0; k < len; k++)
            line_expect.push_back('{ch: line_buf[k], last: 1'b0});
        line_expect.push_back('{ch: CH_NL, last: 1'b0});
    endfunction

    // Advance the mirror by one accepted character and queue the bytes it emits.
    function automatic void fold_and_expand(input logic [CHAR_W-1:0] c);
        int w;
        int t;
        int i;
        int j;
        int keep;
        int rest;
        int first;
        w = width_reg;
        if (w < MIN_WIDTH)
            w = MIN_WIDTH;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        t = (tab_reg == 0) ? 1 : tab_reg;
        i = col_count;
        // A width lowered mid-line pins the column to the last one.
        if (i >= w)
            i = w - 1;
        first = line_expect.size();
        line_buf[i] = c;
        if (c == CH_TAB)
        begin
            line_buf[i] = CH_SP;
            i++;
            while ((i % t) != 0 && i < w)
            begin
                line_buf[i] = CH_SP;
                i++;
            end
            // A tab that lands on the width flushes the whole line, blanks included.
            if (i == w)
            begin
                emit_columns(w);
                i = 0;
            end
        end
        else if (c == CH_NL)
        begin
            emit_columns(i);
            i = 0;
        end
        else
        begin
            i++;
            if (i == w)
            begin
                // Cut after the last nonblank column; an all-blank line goes out whole.
                j = w - 1;
                while (j > 0 && line_buf[j] == CH_SP)
                    j--;
                keep = (line_buf[j] != CH_SP) ? j + 1 : w;
                emit_columns(keep);
                rest = w - keep;
                for (int k = 0; k < rest; k++)
                    line_buf[k] = line_buf[keep + k];
                i = rest;
            end
        end
        col_count = COL_W'(i);
        if (line_expect.size() > first)
            line_expect[line_expect.size() - 1].last = 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, none at all while idling is off.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Text-like stream: words, blanks, tabs, line ends and some arbitrary bytes.
    function automatic logic [CHAR_W-1:0] next_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return CHAR_W'($urandom_range(33, 126));
        if (r < 70)
            return CH_SP;
        if (r < 80)
            return CH_TAB;
        if (r < 88)
            return CH_NL;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic void flag_mismatch(input string what, input out_byte_t want,
                                          input out_byte_t got);
        if (mismatches < 10)
            $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                     what, want.ch, want.last, got.ch, got.last);
        mismatches++;
    endfunction

    // Feeder: one transfer per accepted character, random gaps between items.
    always @(posedge clk)
    begin : feeder
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                fold_and_expand(in_char);
            // Hold a stalled character; otherwise honor the gap, then offer the next one.
            if (in_valid && in_stall)
                ;
            else if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                in_valid <= 1'b1;
                in_char <= pending_chars.pop_front();
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Sink: check each output transfer and drive the stall pattern.
    always @(posedge clk)
    begin : sink
        out_byte_t want;
        out_byte_t got;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{ch: out_char, last: last_of_run};
                if (line_expect.size() == 0)
                    flag_mismatch("unexpected byte", 'x, got);
                else
                begin
                    want = line_expect.pop_front();
                    if (want.ch !== got.ch || want.last !== got.last)
                        flag_mismatch("wrong byte", want, got);
                end
            end
            // Block the output for a long stretch while characters keep coming, so the
            // folder backs up and stalls its input.
            if (hold_left == 0 && holds_done < 2 && out_valid && pending_chars.size() > 10)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // Write one register while the block is idle and track it in the mirror.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LINE_WIDTH: width_reg = val;
            CFG_TAB_STOP:   tab_reg = val;
            default:        ;
        endcase
        @(negedge clk);
    endtask

    // Wait until every character is taken and every expected byte has come out,
    // then let any trailing work inside the block finish.
    task automatic wait_drained();
        while (pending_chars.size() != 0 || in_valid || line_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++)
            pending_chars.push_back(s[k]);
    endtask

    task automatic feed_random(input int count, input bit idle);
        idle_on = idle;
        repeat (count) pending_chars.push_back(next_char());
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: byte extremes, a tab to the stop, a tab that reaches the
        // width and flushes the line, then an empty line.
        pending_chars.push_back(8'h00);
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(CH_TAB);
        push_text("ab");
        pending_chars.push_back(CH_TAB);
        pending_chars.push_back(CH_NL);
        wait_drained();

        // Width below the minimum clamps to two, tab stop zero acts as one:
        // fold with a carried blank, an all-blank fold, a tab reaching the width.
        write_reg(CFG_LINE_WIDTH, 6'd1);
        write_reg(CFG_TAB_STOP, 6'd0);
        push_text("a  ");
        pending_chars.push_back(CH_TAB);
        pending_chars.push_back(CH_TAB);
        pending_chars.push_back(CH_NL);
        wait_drained();

        // Width above the maximum clamps to the buffer size; spare indexes are dropped.
        write_reg(CFG_LINE_WIDTH, 6'd63);
        write_reg(CFG_TAB_STOP, 6'd32);
        write_reg(CFG_SPARE_A, 6'd3);
        write_reg(CFG_SPARE_B, 6'd63);
        pending_chars.push_back(8'h78);
        pending_chars.push_back(CH_TAB);
        wait_drained();

        // Lower the width under a partly filled line; the next byte lands on the
        // last column and folds.
        write_reg(CFG_LINE_WIDTH, 6'd8);
        write_reg(CFG_TAB_STOP, 6'd3);
        push_text("abcdef");
        wait_drained();
        write_reg(CFG_LINE_WIDTH, 6'd4);
        push_text("g");
        pending_chars.push_back(CH_NL);
        wait_drained();

        // Random text under a spread of settings; leftover columns carry across phases,
        // so width changes also hit lines in progress.
        write_reg(CFG_LINE_WIDTH, 6'd2);
        write_reg(CFG_TAB_STOP, 6'd1);
        feed_random(20, 1'b1);
        write_reg(CFG_LINE_WIDTH, 6'd32);
        write_reg(CFG_TAB_STOP, 6'd32);
        feed_random(20, 1'b0);
        write_reg(CFG_LINE_WIDTH, 6'd0);
        write_reg(CFG_TAB_STOP, 6'd0);
        feed_random(20, 1'b1);
        write_reg(CFG_LINE_WIDTH, 6'd63);
        write_reg(CFG_TAB_STOP, 6'd63);
        feed_random(20, 1'b1);
        write_reg(CFG_LINE_WIDTH, 6'd12);
        write_reg(CFG_TAB_STOP, 6'd4);
        feed_random(20, 1'b1);
        write_reg(CFG_LINE_WIDTH, COL_W'($urandom_range(0, 63)));
        write_reg(CFG_TAB_STOP, COL_W'($urandom_range(0, 63)));
        feed_random(20, 1'b1);
        write_reg(CFG_LINE_WIDTH, 6'd16);
        write_reg(CFG_TAB_STOP, 6'd8);
        feed_random(20, 1'b0);
        write_reg(CFG_LINE_WIDTH, 6'd7);
        write_reg(CFG_TAB_STOP, COL_W'($urandom_range(1, 9)));
        feed_random(20, 1'b1);

        if (mismatches == 0 && line_expect.size() == 0)
            $display("line_fold_tab_expand regression: pass");
        else
            $display("line_fold_tab_expand regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lfte_pkg.sv
hdl/lfte_dp.sv
hdl/lfte_ctrl.sv
hdl/line_fold_tab_expand.sv
bench/line_fold_tab_expand_test.sv
